@@ rtl/shell_word_tokenizer_unit_defines.svh @@
// Assertion macros shared by the tokenizer modules.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef SHELL_WORD_TOKENIZER_UNIT_DEFINES_SVH
`define SHELL_WORD_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SWT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/swt_pkg.sv @@
package swt_pkg;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    localparam int unsigned MAX_RES = 3;

    typedef enum logic [2:0] {
        M_PLAIN    = 3'd0,
        M_PLAIN_BS = 3'd1,
        M_DOLLAR   = 3'd2,
        M_SQ       = 3'd3,
        M_DQ       = 3'd4,
        M_DQ_BS    = 3'd5,
        M_AQ       = 3'd6,
        M_AQ_BS    = 3'd7
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       word_end;
    } result_t;

    // All results of one item, slot 0 first.
    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic [1:0]            cnt;
    } lex_out_t;

    // Outcome of one byte in plain mode.
    typedef struct packed {
        logic      emit;
        result_t   res;
        lex_mode_t mode;
        logic      word_open;
    } plain_step_t;

    function automatic result_t mk_byte(input logic [7:0] c);
        result_t r;
        r.out_byte   = c;
        r.byte_valid = 1'b1;
        r.word_end   = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_word_end();
        result_t r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.word_end   = 1'b1;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic plain_step_t plain_step(input logic [7:0] c, input logic wo);
        plain_step_t p;
        p.emit      = 1'b0;
        p.res       = mk_byte(c);
        p.mode      = M_PLAIN;
        p.word_open = wo;
        if (is_space(c)) begin
            if (wo) begin
                p.emit      = 1'b1;
                p.res       = mk_word_end();
                p.word_open = 1'b0;
            end
        end else if (c == CH_BSLASH) begin
            p.mode = M_PLAIN_BS;
        end else if (c == CH_SQUOTE) begin
            p.mode      = M_SQ;
            p.word_open = 1'b1;
        end else if (c == CH_DQUOTE) begin
            p.mode      = M_DQ;
            p.word_open = 1'b1;
        end else if (c == CH_DOLLAR) begin
            p.mode = M_DOLLAR;
        end else begin
            p.emit      = 1'b1;
            p.word_open = 1'b1;
        end
        return p;
    endfunction

endpackage

@@ rtl/swt_lexer.sv @@
`include "shell_word_tokenizer_unit_defines.svh"

module swt_lexer import swt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       has_byte,
    input  logic       end_of_line,
    output lex_out_t   lx
);

    lex_mode_t mode_reg, mode_next;
    logic      word_open_reg, word_open_next;

    always_comb begin
        lex_mode_t             m;
        logic                  wo;
        logic [1:0]            k;
        result_t [MAX_RES-1:0] res;
        plain_step_t           pa;
        logic [7:0]            c;

        m   = mode_reg;
        wo  = word_open_reg;
        k   = 2'd0;
        res = '0;
        pa  = '0;
        c   = in_byte;

        if (has_byte) begin
            unique case (m)
                M_PLAIN: begin
                    pa = plain_step(c, wo);
                    m  = pa.mode;
                    wo = pa.word_open;
                    if (pa.emit) begin
                        res[k] = pa.res;
                        k      = k + 2'd1;
                    end
                end
                M_PLAIN_BS: begin
                    m = M_PLAIN;
                    // drop backslash-newline as a line join
                    if (c != CH_LF && c != CH_CR) begin
                        res[k] = mk_byte(c);
                        k      = k + 2'd1;
                        wo     = 1'b1;
                    end
                end
                M_DOLLAR: begin
                    if (c == CH_SQUOTE) begin
                        m  = M_AQ;
                        wo = 1'b1;
                    end else begin
                        res[k] = mk_byte(CH_DOLLAR);
                        k      = k + 2'd1;
                        pa     = plain_step(c, 1'b1);
                        m      = pa.mode;
                        wo     = pa.word_open;
                        if (pa.emit) begin
                            res[k] = pa.res;
                            k      = k + 2'd1;
                        end
                    end
                end
                M_SQ: begin
                    if (c == CH_SQUOTE) begin
                        m = M_PLAIN;
                    end else begin
                        res[k] = mk_byte(c);
                        k      = k + 2'd1;
                        wo     = 1'b1;
                    end
                end
                M_DQ: begin
                    if (c == CH_DQUOTE) begin
                        m = M_PLAIN;
                    end else if (c == CH_BSLASH) begin
                        m = M_DQ_BS;
                    end else begin
                        res[k] = mk_byte(c);
                        k      = k + 2'd1;
                        wo     = 1'b1;
                    end
                end
                M_DQ_BS: begin
                    m      = M_DQ;
                    res[k] = mk_byte(c);
                    k      = k + 2'd1;
                    wo     = 1'b1;
                end
                M_AQ: begin
                    if (c == CH_SQUOTE) begin
                        m = M_PLAIN;
                    end else if (c == CH_BSLASH) begin
                        m = M_AQ_BS;
                    end else begin
                        res[k] = mk_byte(c);
                        k      = k + 2'd1;
                        wo     = 1'b1;
                    end
                end
                M_AQ_BS: begin
                    m = M_AQ;
                    if (c == CH_LOW_N) begin
                        c = CH_LF;
                    end else if (c == CH_LOW_T) begin
                        c = CH_TAB;
                    end else if (c == CH_LOW_R) begin
                        c = CH_CR;
                    end
                    res[k] = mk_byte(c);
                    k      = k + 2'd1;
                    wo     = 1'b1;
                end
            endcase
        end

        if (end_of_line) begin
            // emit a pending '$' or in-quote backslash, then close the word
            if (m == M_DOLLAR) begin
                if (k != 2'd3) begin
                    res[k] = mk_byte(CH_DOLLAR);
                    k      = k + 2'd1;
                end
                wo = 1'b1;
            end else if (m == M_DQ_BS || m == M_AQ_BS) begin
                if (k != 2'd3) begin
                    res[k] = mk_byte(CH_BSLASH);
                    k      = k + 2'd1;
                end
                wo = 1'b1;
            end
            if (wo && k != 2'd3) begin
                res[k] = mk_word_end();
                k      = k + 2'd1;
            end
            m  = M_PLAIN;
            wo = 1'b0;
        end

        lx.res         = res;
        lx.cnt         = k;
        mode_next      = step ? m  : mode_reg;
        word_open_next = step ? wo : word_open_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_PLAIN;
            word_open_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            word_open_reg <= word_open_next;
        end
    end

    `SWT_ASSERT_NEXT(a_eol_resets_mode, step && end_of_line, mode_reg == M_PLAIN && !word_open_reg, "end of line left lexer state open")
    `SWT_ASSERT_NOW(a_empty_item_silent, step && !has_byte && !end_of_line, lx.cnt == 2'd0, "empty item produced results")
    `SWT_ASSERT_NOW(a_word_end_no_byte, lx.res[0].word_end, !lx.res[0].byte_valid, "word end result carries a byte")

endmodule

@@ rtl/swt_result_buf.sv @@
`include "shell_word_tokenizer_unit_defines.svh"

module swt_result_buf import swt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  lex_out_t   lx,
    output logic       buf_free,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       word_end,
    output logic       run_last
);

    result_t [MAX_RES-1:0] res_reg, res_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic                  take, last_take;
    result_t               cur;

    assign cur        = res_reg[idx_reg];
    assign out_valid  = valid_reg;
    assign out_byte   = cur.out_byte;
    assign byte_valid = cur.byte_valid;
    assign word_end   = cur.word_end;
    assign run_last   = (idx_reg == cnt_reg - 2'd1);

    assign take      = valid_reg && !out_stall;
    assign last_take = take && run_last;
    assign buf_free  = !valid_reg || last_take;

    always_comb begin
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            res_next   = lx.res;
            cnt_next   = lx.cnt;
            idx_next   = 2'd0;
            valid_next = 1'b1;
        end else if (last_take) begin
            valid_next = 1'b0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    `SWT_ASSERT_NOW(a_idx_in_range, valid_reg, idx_reg < cnt_reg, "result index past count")
    `SWT_ASSERT_NOW(a_nonempty, valid_reg, cnt_reg != 2'd0, "buffer holds an empty item")
    `SWT_ASSERT_NEXT(a_load_starts, load, valid_reg && idx_reg == 2'd0, "load did not restart the run")

endmodule

@@ rtl/shell_word_tokenizer_unit.sv @@
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// input    | in_valid, in_stall, in_byte, has_byte,          | in
//          | end_of_line                                    |
// output   | out_valid, out_stall, out_byte, byte_valid,     | out
//          | word_end, run_last                             |
//
// One input item per cycle when it yields at most one result and out_stall is low; an
// item with more results holds back the next one while the result buffer hands them out.
// Path: input register, combinational lexer logic, registered result buffer, which
// drives the results. Items with no result retire from the input register without the buffer.
// Reset is asynchronous and returns the lexer to plain mode with no open word.
// out_stall backs up into in_stall only once the input register holds an item.
module shell_word_tokenizer_unit import swt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       has_byte,
    input  logic       end_of_line,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       word_end,
    output logic       run_last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       has_byte_reg;
    logic       eol_reg;
    logic       accept, advance, load, buf_free;
    lex_out_t   lx;

    // advance the held item when its results fit, or when it has none
    assign advance  = in_valid_reg && (lx.cnt == 2'd0 || buf_free);
    assign load     = advance && lx.cnt != 2'd0;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= in_byte;
            has_byte_reg <= has_byte;
            eol_reg      <= end_of_line;
        end
    end

    swt_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .in_byte     (in_byte_reg),
        .has_byte    (has_byte_reg),
        .end_of_line (eol_reg),
        .lx          (lx)
    );

    swt_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .lx         (lx),
        .buf_free   (buf_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .word_end   (word_end),
        .run_last   (run_last)
    );

endmodule

@@ sim/tb_shell_word_tokenizer_unit.sv @@
module tb_shell_word_tokenizer_unit import swt_pkg::*;
();

    localparam int RANDOM_ITEMS = 140;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic [7:0] ch;
        logic       hb;
        logic       eol;
    } line_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       is_end;
        logic       last;
    } token_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] in_byte     = 8'h00;
    logic       has_byte    = 1'b0;
    logic       end_of_line = 1'b0;
    logic       out_stall   = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       word_end;
    logic       run_last;

    line_item_t line_q[$];
    token_t     token_q[$];
    token_t     step_buf[$];

    lex_mode_t  lex_state    = M_PLAIN;
    logic       word_live    = 1'b0;
    int         live_items   = 0;
    int         send_wait    = 0;
    int         recv_wait    = 0;
    bit         send_calm    = 1'b0;
    bit         recv_calm    = 1'b0;
    int         results_seen = 0;
    int         fail_count   = 0;
    int         cycle_count  = 0;

    shell_word_tokenizer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .has_byte    (has_byte),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .word_end    (word_end),
        .run_last    (run_last)
    );

    always #6 clk = ~clk;

    // ---------------- token predictor ----------------

    function automatic void add_token(logic [7:0] b, logic bv, logic we);
        step_buf.insert(step_buf.size(), {b, bv, we, 1'b0});
    endfunction

    function automatic void add_char(logic [7:0] b);
        word_live = 1'b1;
        add_token(b, 1'b1, 1'b0);
    endfunction

    function automatic logic blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic void plain_char(logic [7:0] c);
        if (blank(c))
        begin
            if (word_live)
            begin
                add_token(8'h00, 1'b0, 1'b1);
                word_live = 1'b0;
            end
        end
        else if (c == CH_BSLASH)
            lex_state = M_PLAIN_BS;
        else if (c == CH_SQUOTE)
        begin
            word_live = 1'b1;
            lex_state = M_SQ;
        end
        else if (c == CH_DQUOTE)
        begin
            word_live = 1'b1;
            lex_state = M_DQ;
        end
        else if (c == CH_DOLLAR)
            lex_state = M_DOLLAR;
        else
            add_char(c);
    endfunction

    function automatic void tokenize_item(line_item_t it);
        logic [7:0] c;
        token_t     tok;
        c = it.ch;
        step_buf.delete();
        if (it.hb)
        begin
            case (lex_state)
                M_PLAIN:
                    plain_char(c);
                M_PLAIN_BS:
                begin
                    lex_state = M_PLAIN;
                    // backslash-newline is a line join: drop both
                    if (c != CH_LF && c != CH_CR)
                        add_char(c);
                end
                M_DOLLAR:
                begin
                    if (c == CH_SQUOTE)
                    begin
                        word_live = 1'b1;
                        lex_state = M_AQ;
                    end
                    else
                    begin
                        lex_state = M_PLAIN;
                        add_char(CH_DOLLAR);
                        plain_char(c);
                    end
                end
                M_SQ:
                begin
                    if (c == CH_SQUOTE)
                        lex_state = M_PLAIN;
                    else
                        add_char(c);
                end
                M_DQ:
                begin
                    if (c == CH_DQUOTE)
                        lex_state = M_PLAIN;
                    else if (c == CH_BSLASH)
                        lex_state = M_DQ_BS;
                    else
                        add_char(c);
                end
                M_DQ_BS:
                begin
                    lex_state = M_DQ;
                    add_char(c);
                end
                M_AQ:
                begin
                    if (c == CH_SQUOTE)
                        lex_state = M_PLAIN;
                    else if (c == CH_BSLASH)
                        lex_state = M_AQ_BS;
                    else
                        add_char(c);
                end
                default:
                begin
                    lex_state = M_AQ;
                    case (c)
                        CH_LOW_N: add_char(CH_LF);
                        CH_LOW_T: add_char(CH_TAB);
                        CH_LOW_R: add_char(CH_CR);
                        default:  add_char(c);
                    endcase
                end
            endcase
        end
        if (it.eol)
        begin
            // flush what is pending, then close the word
            if (lex_state == M_DOLLAR)
                add_char(CH_DOLLAR);
            else if (lex_state == M_DQ_BS || lex_state == M_AQ_BS)
                add_char(CH_BSLASH);
            if (word_live)
                add_token(8'h00, 1'b0, 1'b1);
            lex_state = M_PLAIN;
            word_live = 1'b0;
        end
        foreach (step_buf[i])
        begin
            tok      = step_buf[i];
            tok.last = (i == step_buf.size() - 1);
            token_q.insert(token_q.size(), tok);
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void put_item(logic [7:0] c, logic hb, logic eol);
        line_q.insert(line_q.size(), {c, hb, eol});
        if (hb || eol)
            live_items++;
    endfunction

    function automatic void put_char(logic [7:0] c);
        put_item(c, 1'b1, 1'b0);
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 7))
            0:       return CH_SQUOTE;
            1:       return CH_DQUOTE;
            2:       return CH_BSLASH;
            3:       return CH_DOLLAR;
            4:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 6))
            0:       return CH_LOW_N;
            1:       return CH_LOW_T;
            2:       return CH_LOW_R;
            3:       return CH_BSLASH;
            4:       return CH_SQUOTE;
            default: return pick_text();
        endcase
    endfunction

    function automatic void report_fail(string what, token_t want, token_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected b=%02h v=%0b e=%0b l=%0b, got b=%02h v=%0b e=%0b l=%0b",
                     what, want.data, want.is_byte, want.is_end, want.last,
                     got.data, got.is_byte, got.is_end, got.last);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        line_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                tokenize_item({in_byte, has_byte, end_of_line});
                if ($urandom_range(0, 19) == 0)
                    send_calm = !send_calm;
                send_wait = send_calm ? 0 : $urandom_range(0, 15);
            end
            // hold a stalled item, otherwise advance
            if (!in_valid || !in_stall)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (line_q.size() > 0)
                begin
                    it = line_q.pop_front();
                    in_byte     <= it.ch;
                    has_byte    <= it.hb;
                    end_of_line <= it.eol;
                    in_valid    <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor and receiver ----------------

    always @(posedge clk)
    begin
        token_t seen;
        token_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {out_byte, byte_valid, word_end, run_last};
                results_seen++;
                if (token_q.size() == 0)
                    report_fail("unexpected result", '0, seen);
                else
                begin
                    want = token_q.pop_front();
                    if (seen.data !== want.data || seen.is_byte !== want.is_byte ||
                        seen.is_end !== want.is_end || seen.last !== want.last)
                        report_fail("mismatch", want, seen);
                end
                if ($urandom_range(0, 19) == 0)
                    recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 15);
                // one long back-pressure stretch to fill the pipeline
                if (results_seen == HOLD_AT)
                    recv_wait = HOLD_CYCLES;
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_shell_word_tokenizer_unit: FAIL");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int base;
        int len;

        // directed: extremes, quoting modes, and end-of-line flushes
        put_item(8'h00, 1'b0, 1'b0);          // empty step
        put_item(8'hFF, 1'b0, 1'b1);          // bare end of line, no word open
        put_char(8'hFF);
        put_char(8'h00);
        put_char(CH_SPACE);
        put_char(CH_SQUOTE);                  // empty quoted word
        put_char(CH_SQUOTE);
        put_char(CH_SPACE);
        put_char(CH_BSLASH);                  // line join
        put_char(CH_LF);
        put_char(CH_DOLLAR);                  // dollar not followed by a quote
        put_item(8'h7A, 1'b1, 1'b1);
        put_char(CH_DOLLAR);                  // dollar-quote with escape
        put_char(CH_SQUOTE);
        put_char(CH_BSLASH);
        put_char(CH_LOW_N);
        put_char(CH_SQUOTE);
        put_char(CH_DQUOTE);                  // backslash pending in double quote
        put_char(CH_BSLASH);
        put_item(8'h00, 1'b0, 1'b1);
        put_char(CH_BSLASH);                  // bare backslash at end of line
        put_item(8'h00, 1'b0, 1'b1);
        put_char(CH_SQUOTE);                  // unterminated quote
        put_item(8'h61, 1'b1, 1'b1);
        put_item(CH_DOLLAR, 1'b1, 1'b1);      // dollar pending at end of line

        base = live_items;
        while (live_items < base + RANDOM_ITEMS)
        begin
            len = $urandom_range(0, 4);
            case ($urandom_range(0, 11))
                0:
                    put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                1, 11:
                    repeat (len + 1)
                        put_char(8'($urandom_range(8'h21, 8'h7E)));
                2:
                begin
                    put_char(CH_SQUOTE);
                    repeat (len)
                        put_char(pick_text());
                    if ($urandom_range(0, 3) != 0)
                        put_char(CH_SQUOTE);
                end
                3:
                begin
                    put_char(CH_DQUOTE);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 2) == 0)
                            put_char(CH_BSLASH);
                        put_char(pick_text());
                    end
                    if ($urandom_range(0, 3) != 0)
                        put_char(CH_DQUOTE);
                end
                4:
                begin
                    put_char(CH_DOLLAR);
                    put_char(CH_SQUOTE);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            put_char(CH_BSLASH);
                            put_char(pick_escape());
                        end
                        else
                            put_char(pick_text());
                    end
                    if ($urandom_range(0, 3) != 0)
                        put_char(CH_SQUOTE);
                end
                5:
                begin
                    put_char(CH_BSLASH);
                    put_char($urandom_range(0, 1) ? pick_blank() : pick_text());
                end
                6, 10:
                    put_char(pick_blank());
                7:
                    put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                8:
                begin
                    put_char(CH_DOLLAR);
                    put_char($urandom_range(0, 1) ? pick_blank() : pick_text());
                end
                default:
                    put_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            endcase
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (line_q.size() != 0 || in_valid || token_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_shell_word_tokenizer_unit: PASS");
        else
            $display("tb_shell_word_tokenizer_unit: FAIL");
        $finish;
    end

endmodule
